// ===== design/psg_pkg.sv =====
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, constants and the attenuation table for the tone/noise mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package psg_pkg;

    localparam int TONE_W   = 10;
    localparam int ATTEN_W  = 4;
    localparam int LFSR_W   = 16;
    localparam int SAMPLE_W = 15;
    localparam int NUM_TONE = 3;
    localparam int NUM_CHAN = 4;

    // Latched channel code of the noise voice
    localparam logic [1:0] NOISE_CHAN = 2'd3;

    // Noise shift-rate codes
    localparam logic [1:0] RATE_16    = 2'd0;
    localparam logic [1:0] RATE_32    = 2'd1;
    localparam logic [1:0] RATE_64    = 2'd2;
    localparam logic [1:0] RATE_TONE2 = 2'd3;

    localparam logic [TONE_W-1:0]  NOISE_RELOAD_16 = 10'h010;
    localparam logic [TONE_W-1:0]  NOISE_RELOAD_32 = 10'h020;
    localparam logic [TONE_W-1:0]  NOISE_RELOAD_64 = 10'h040;
    localparam logic [LFSR_W-1:0]  NOISE_SEED      = 16'h8000;
    localparam logic [ATTEN_W-1:0] ATTEN_MUTE      = 4'hF;

    // Noise control register: bit 2 white, bits 1:0 rate
    typedef struct packed {
        logic       white;
        logic [1:0] rate;
    } noise_ctrl_t;

    typedef logic [ATTEN_W-1:0] atten_t;

    function automatic logic [SAMPLE_W-1:0] atten_level(input logic [ATTEN_W-1:0] att);
        logic [SAMPLE_W-1:0] lvl;
        unique case (att)
            4'd0:    lvl = 15'd32767;
            4'd1:    lvl = 15'd26028;
            4'd2:    lvl = 15'd20675;
            4'd3:    lvl = 15'd16422;
            4'd4:    lvl = 15'd13045;
            4'd5:    lvl = 15'd10362;
            4'd6:    lvl = 15'd8231;
            4'd7:    lvl = 15'd6568;
            4'd8:    lvl = 15'd5193;
            4'd9:    lvl = 15'd4125;
            4'd10:   lvl = 15'd3277;
            4'd11:   lvl = 15'd2603;
            4'd12:   lvl = 15'd2067;
            4'd13:   lvl = 15'd1642;
            4'd14:   lvl = 15'd1304;
            default: lvl = 15'd0;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ===== design/psg_tone_gen.sv =====
// ----------------------------------------------------------------------------
// psg_tone_gen
// One square-wave voice: down-counter with period reload and output toggle.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone_gen
    import psg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              tick_en,
    input  wire logic [TONE_W-1:0] period,
    output logic                   level_next
);

    logic [TONE_W-1:0] counter_reg, counter_next, counter_dec;
    logic              level_reg;

    always_comb begin
        counter_dec  = (counter_reg != '0) ? counter_reg - 1'b1 : counter_reg;
        counter_next = counter_reg;
        level_next   = level_reg;
        if (tick_en) begin
            counter_next = counter_dec;
            if (counter_dec == '0) begin
                counter_next = period;
                // zero period pins the output high
                level_next   = (period == '0) ? 1'b1 : ~level_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            level_reg   <= 1'b0;
        end else begin
            counter_reg <= counter_next;
            level_reg   <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/psg_noise_gen.sv =====
// ----------------------------------------------------------------------------
// psg_noise_gen
// Noise voice: rate counter and 16-bit LFSR, white or periodic feedback.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_noise_gen
    import psg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              tick_en,
    input  wire logic              lfsr_load,
    input  wire noise_ctrl_t       ctrl,
    input  wire logic [TONE_W-1:0] tone2_period,
    output logic                   level_next
);

    logic [TONE_W-1:0] counter_reg, counter_next, counter_dec, reload;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic              level_reg;
    logic              feedback;

    always_comb begin
        unique case (ctrl.rate)
            RATE_16:    reload = NOISE_RELOAD_16;
            RATE_32:    reload = NOISE_RELOAD_32;
            RATE_64:    reload = NOISE_RELOAD_64;
            RATE_TONE2: reload = tone2_period;
            default:    reload = tone2_period;
        endcase
        feedback     = lfsr_reg[0] ^ (ctrl.white & lfsr_reg[3]);
        counter_dec  = (counter_reg != '0) ? counter_reg - 1'b1 : counter_reg;
        counter_next = counter_reg;
        lfsr_next    = lfsr_reg;
        level_next   = level_reg;
        if (lfsr_load) begin
            lfsr_next = NOISE_SEED;
        end else if (tick_en) begin
            counter_next = counter_dec;
            if (counter_dec == '0) begin
                counter_next = reload;
                lfsr_next    = {feedback, lfsr_reg[LFSR_W-1:1]};
                level_next   = lfsr_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            lfsr_reg    <= '0;
            level_reg   <= 1'b0;
        end else begin
            counter_reg <= counter_next;
            lfsr_reg    <= lfsr_next;
            level_reg   <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/psg_mixer.sv =====
// ----------------------------------------------------------------------------
// psg_mixer
// Gates each voice's table level by its output and averages the four.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_mixer
    import psg_pkg::*;
(
    input  wire logic [NUM_CHAN-1:0] levels,
    input  wire atten_t              atten [NUM_CHAN],
    output logic [SAMPLE_W-1:0]      sample
);

    logic [SAMPLE_W+1:0] sum;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NUM_CHAN; i++) begin
            if (levels[i]) begin
                sum = sum + {2'b00, atten_level(atten[i])};
            end
        end
        sample = sum[SAMPLE_W+1:2];
    end

endmodule

`default_nettype wire

// ===== design/psg_tone_noise_mixer_unit.sv =====
// A tick transfer passes the input register, then updates the voice state and is
//   mixed into the result register.
// Throughput: 1 item per cycle while no tick waits on a stalled result; command bytes and ticks alike.
// A stalled result holds ticks in the input register; command bytes pass until a tick is held.
// Reset: aresetn synchronous, active low; all voices silent, attenuation muted,
//   LFSR zero until a noise-control write. s_ready rises after reset once run_reg is set.
// ----------------------------------------------------------------------------
// psg_tone_noise_mixer_unit
// Three square tone voices plus an LFSR noise voice, command decode and mix.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_tone_noise_mixer_unit
    import psg_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // command / tick input
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_func,
    input  wire logic [7:0]          s_cmd_byte,
    // sample output
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SAMPLE_W-1:0]      m_mixed_sample
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       run_reg;
    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       tick_en;
    logic       wr_en;

    // Output register
    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample;

    // A command byte never needs the output; a tick needs a free result slot.
    assign advance = in_valid_reg & (~in_func_reg | ~m_valid_reg | m_ready);
    assign tick_en = advance & in_func_reg;
    assign wr_en   = advance & ~in_func_reg;
    assign s_ready = run_reg & (~in_valid_reg | advance);

    // ------------------------------------------------------------------
    // Register file: latch, tone periods, attenuation, noise control
    // ------------------------------------------------------------------
    logic [1:0]        latched_chan_reg;
    logic              latched_vol_reg;
    logic [TONE_W-1:0] period_reg [NUM_TONE];
    atten_t            atten_reg  [NUM_CHAN];
    noise_ctrl_t       noise_ctrl_reg;

    logic       is_latch;
    logic [1:0] wr_chan;
    logic       wr_vol;
    logic       lfsr_load;

    // A latch byte redirects the write in the same transfer.
    assign is_latch  = in_byte_reg[7];
    assign wr_chan   = is_latch ? in_byte_reg[6:5] : latched_chan_reg;
    assign wr_vol    = is_latch ? in_byte_reg[4]   : latched_vol_reg;
    assign lfsr_load = wr_en & ~wr_vol & (wr_chan == NOISE_CHAN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg          <= 1'b0;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            latched_chan_reg <= '0;
            latched_vol_reg  <= 1'b0;
            noise_ctrl_reg   <= '0;
            for (int i = 0; i < NUM_TONE; i++) begin
                period_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CHAN; i++) begin
                atten_reg[i] <= ATTEN_MUTE;
            end
        end else begin
            run_reg <= 1'b1;

            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (tick_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (wr_en) begin
                latched_chan_reg <= wr_chan;
                latched_vol_reg  <= wr_vol;
                if (wr_vol) begin
                    atten_reg[wr_chan] <= in_byte_reg[3:0];
                end else if (wr_chan == NOISE_CHAN) begin
                    noise_ctrl_reg <= noise_ctrl_t'(in_byte_reg[2:0]);
                end else if (is_latch) begin
                    period_reg[wr_chan] <= {period_reg[wr_chan][TONE_W-1:4], in_byte_reg[3:0]};
                end else begin
                    period_reg[wr_chan] <= {in_byte_reg[5:0], period_reg[wr_chan][3:0]};
                end
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_byte_reg <= s_cmd_byte;
        end
        if (tick_en) begin
            sample_reg <= sample;
        end
    end

    // ------------------------------------------------------------------
    // Voices: next levels feed the mixer in the same cycle as the tick
    // ------------------------------------------------------------------
    logic [NUM_CHAN-1:0] levels;

    for (genvar g = 0; g < NUM_TONE; g++) begin : g_tone
        psg_tone_gen u_tone (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .tick_en    (tick_en),
            .period     (period_reg[g]),
            .level_next (levels[g])
        );
    end

    psg_noise_gen u_noise (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .lfsr_load    (lfsr_load),
        .ctrl         (noise_ctrl_reg),
        .tone2_period (period_reg[2]),
        .level_next   (levels[NOISE_CHAN])
    );

    psg_mixer u_mixer (
        .levels (levels),
        .atten  (atten_reg),
        .sample (sample)
    );

    assign m_valid        = m_valid_reg;
    assign m_mixed_sample = sample_reg;

endmodule

`default_nettype wire

// ===== design/psg_checker.sv =====
// ----------------------------------------------------------------------------
// psg_checker
// Port-level checks on the mixer unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psg_checker
    import psg_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                s_func,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [SAMPLE_W-1:0] m_mixed_sample
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // with no result pending the input side must be open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_valid |-> s_ready)
        else $error("s_ready low with empty output");

    // a fresh result only follows a tick transfer, through the input and result registers
    a_result_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_func, 2))
        else $error("result without a tick transfer");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mixed_sample))
        else $error("stalled result changed");

endmodule

bind psg_tone_noise_mixer_unit psg_checker u_psg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_func         (s_func),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_mixed_sample (m_mixed_sample)
);

`default_nettype wire

// ===== tb/sv/tb_psg_tone_noise_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_psg_tone_noise_mixer_unit
// Self-checking bench for the tone/noise mixer. Command bytes and ticks are
// streamed through the input channel. A local model of the voices predicts
// each tick's mixed sample, and the monitor compares it with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_psg_tone_noise_mixer_unit
    import psg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;
    localparam int   LATCH_BIT  = 7;
    // Worst case is about 1500 items; the limit is set far above what they need.
    localparam int   CYCLE_LIMIT = 400000;
    // Settle time after the last sample: input and result registers plus margin
    localparam int   TAIL_CYCLES = 16;

    // Sample level for each attenuation step
    localparam logic [SAMPLE_W-1:0] LEVEL_OF_ATTEN [16] = '{
        15'd32767, 15'd26028, 15'd20675, 15'd16422, 15'd13045, 15'd10362,
        15'd8231,  15'd6568,  15'd5193,  15'd4125,  15'd3277,  15'd2603,
        15'd2067,  15'd1642,  15'd1304,  15'd0
    };

    typedef struct {
        bit         drain;  // hold the sender until every sample is back
        logic       func;
        logic [7:0] cmd;
    } psg_item_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_func = FUNC_WRITE;
    logic [7:0]          s_cmd_byte = 8'h00;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SAMPLE_W-1:0] m_mixed_sample;

    psg_tone_noise_mixer_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_cmd_byte     (s_cmd_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mixed_sample (m_mixed_sample)
    );

    // Voice state mirrored from the block, at its reset values
    logic [TONE_W-1:0] tone_per [NUM_TONE] = '{default: '0};
    logic [TONE_W-1:0] tone_cnt [NUM_TONE] = '{default: '0};
    logic              tone_lvl [NUM_TONE] = '{default: 1'b0};
    atten_t            atten    [NUM_CHAN] = '{default: ATTEN_MUTE};
    logic [TONE_W-1:0] noise_cnt = '0;
    noise_ctrl_t       noise_ctl = '0;
    logic [LFSR_W-1:0] lfsr = '0;
    logic              noise_lvl = 1'b0;
    logic [1:0]        sel_chan = '0;
    logic              sel_vol = 1'b0;

    psg_item_t           pending [$];
    logic [SAMPLE_W-1:0] due_samples [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycles = 0;
    int errors = 0;
    int n_writes = 0;
    int n_ticks = 0;
    int n_checked = 0;
    int n_drains = 0;

    // ------------------------------------------------------------------------
    // Voice model: apply one accepted transfer, queue the sample a tick makes
    // ------------------------------------------------------------------------
    task automatic apply_to_voices(input logic func, input logic [7:0] cmd);
        logic        feedback;
        int          sum;
        if (func == FUNC_WRITE) begin
            n_writes++;
            // Latch byte picks voice and register; data byte reuses the latch
            if (cmd[LATCH_BIT]) begin
                sel_chan = cmd[6:5];
                sel_vol  = cmd[4];
            end
            if (sel_vol) begin
                atten[sel_chan] = cmd[3:0];
            end else if (sel_chan == NOISE_CHAN) begin
                // Any noise-control write reseeds the LFSR
                noise_ctl = cmd[2:0];
                lfsr      = NOISE_SEED;
            end else if (cmd[LATCH_BIT]) begin
                tone_per[sel_chan][3:0] = cmd[3:0];
            end else begin
                tone_per[sel_chan][9:4] = cmd[5:0];
            end
        end else begin
            n_ticks++;
            for (int v = 0; v < NUM_TONE; v++) begin
                if (tone_cnt[v] != '0) tone_cnt[v]--;
                if (tone_cnt[v] == '0) begin
                    tone_cnt[v] = tone_per[v];
                    // Period zero pins the voice high instead of toggling
                    if (tone_per[v] == '0) tone_lvl[v] = 1'b1;
                    else tone_lvl[v] = ~tone_lvl[v];
                end
            end
            if (noise_cnt != '0) noise_cnt--;
            if (noise_cnt == '0) begin
                // Rate from tone 2 may reload zero: shift on every tick then
                case (noise_ctl.rate)
                    RATE_16: noise_cnt = NOISE_RELOAD_16;
                    RATE_32: noise_cnt = NOISE_RELOAD_32;
                    RATE_64: noise_cnt = NOISE_RELOAD_64;
                    default: noise_cnt = tone_per[2];
                endcase
                feedback  = lfsr[0] ^ (noise_ctl.white & lfsr[3]);
                noise_lvl = lfsr[0];
                lfsr      = {feedback, lfsr[LFSR_W-1:1]};
            end
            sum = 0;
            for (int v = 0; v < NUM_TONE; v++) begin
                if (tone_lvl[v]) sum += LEVEL_OF_ATTEN[atten[v]];
            end
            if (noise_lvl) sum += LEVEL_OF_ATTEN[atten[NOISE_CHAN]];
            due_samples.push_back(SAMPLE_W'(sum / 4));
        end
    endtask

    task automatic push_item(input logic func, input logic [7:0] cmd);
        pending.push_back('{drain: 1'b0, func: func, cmd: cmd});
    endtask

    task automatic push_drain();
        pending.push_back('{drain: 1'b1, func: FUNC_WRITE, cmd: 8'h00});
    endtask

    // Mostly ticks between command bursts; data bytes often small so tone
    // and noise periods stay short and the voices keep moving.
    task automatic push_random(input int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                push_item(FUNC_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 78) begin
                push_item(FUNC_WRITE, 8'h80 | 8'($urandom_range(0, 127)));
            end else if (pick < 89) begin
                push_item(FUNC_WRITE, 8'($urandom_range(0, 127)));
            end else begin
                push_item(FUNC_WRITE, 8'($urandom_range(0, 3)) | 8'($urandom_range(0, 1) << 6));
            end
        end
    endtask

    task automatic wait_queue_empty();
        while (pending.size() != 0 || s_valid) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d items pending, %0d samples due",
                     $realtime, cycles, pending.size(), due_samples.size());
            $display("tb_psg_tone_noise_mixer_unit failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: one transfer per handshake; payload is held while valid is high
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic       next_valid;
        logic       next_func;
        logic [7:0] next_cmd;
        psg_item_t  item;
        next_valid = s_valid;
        next_func  = s_func;
        next_cmd   = s_cmd_byte;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_to_voices(s_func, s_cmd_byte);
                next_valid = 1'b0;
            end
            if (!next_valid && pending.size() != 0) begin
                if (pending[0].drain) begin
                    // Sender holds off until the output side has caught up
                    if (due_samples.size() == 0) begin
                        void'(pending.pop_front());
                        n_drains++;
                    end
                end else if ($urandom_range(0, 99) >= tx_idle_pct) begin
                    item       = pending.pop_front();
                    next_valid = 1'b1;
                    next_func  = item.func;
                    next_cmd   = item.cmd;
                end
            end
        end
        s_valid    <= next_valid;
        s_func     <= next_func;
        s_cmd_byte <= next_cmd;
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each sample transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [SAMPLE_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_samples.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, actual %0d",
                             $realtime, m_mixed_sample);
                    errors++;
                end else begin
                    want = due_samples.pop_front();
                    n_checked++;
                    if (m_mixed_sample !== want) begin
                        $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                                 $realtime, want, m_mixed_sample);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed opening, then three random phases with changing
    // idle patterns on both sides
    // ------------------------------------------------------------------------
    initial begin
        tx_idle_pct = 34;
        rx_idle_pct = 86;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // LFSR never written and all voices muted: silence
        push_item(FUNC_TICK, 8'hFF);
        push_item(FUNC_TICK, 8'h00);
        // Full volume on tone 0; period zero pins it high
        push_item(FUNC_WRITE, 8'h90);
        push_item(FUNC_TICK, 8'h5A);
        // Noise volume muted by latch byte, then white noise at tone-2 rate
        // while tone 2 is zero: counter reloads zero, LFSR shifts every tick
        push_item(FUNC_WRITE, 8'hFF);
        push_item(FUNC_WRITE, 8'hE7);
        push_item(FUNC_WRITE, 8'hF0);
        push_item(FUNC_TICK, 8'hA5);
        push_item(FUNC_TICK, 8'h00);
        push_item(FUNC_TICK, 8'hFF);
        // Tone 0 low nibble by latch, upper bits cleared by data byte
        push_item(FUNC_WRITE, 8'h83);
        push_item(FUNC_WRITE, 8'h00);
        push_item(FUNC_TICK, 8'h00);
        // Tone 1: volume 2, period 0x3F1 (largest upper bits)
        push_item(FUNC_WRITE, 8'hB2);
        push_item(FUNC_WRITE, 8'hA1);
        push_item(FUNC_WRITE, 8'h7F);
        // Tone 2: volume 14, period 0x1F
        push_item(FUNC_WRITE, 8'hDE);
        push_item(FUNC_WRITE, 8'hCF);
        push_item(FUNC_WRITE, 8'h01);
        // Noise rates 16, 32 and, by data byte, 64 white
        push_item(FUNC_WRITE, 8'hE4);
        push_item(FUNC_TICK, 8'h3C);
        push_item(FUNC_WRITE, 8'hE1);
        push_item(FUNC_WRITE, 8'h06);
        // Noise volume by latch then by data byte
        push_item(FUNC_WRITE, 8'hF8);
        push_item(FUNC_WRITE, 8'h0C);
        push_item(FUNC_TICK, 8'hC3);
        push_drain();

        push_random(240);
        push_drain();
        push_random(235);
        wait_queue_empty();

        tx_idle_pct = 86;
        rx_idle_pct = 34;
        push_random(475);
        push_drain();
        wait_queue_empty();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_random(475);
        wait_queue_empty();

        while (due_samples.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d command writes and %0d ticks; %0d samples checked, %0d errors.",
                 n_writes, n_ticks, n_checked, errors);
        $display("Three idle patterns on both channels, %0d full drains of the output.",
                 n_drains);
        if (errors == 0 && due_samples.size() == 0) begin
            $display("tb_psg_tone_noise_mixer_unit passed");
        end else begin
            $display("tb_psg_tone_noise_mixer_unit failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/psg_pkg.sv
design/psg_tone_gen.sv
design/psg_noise_gen.sv
design/psg_mixer.sv
design/psg_tone_noise_mixer_unit.sv
design/psg_checker.sv
tb/sv/tb_psg_tone_noise_mixer_unit.sv
